>>> rtl/core/mtbd_pkg.sv
// Package for the bounded-draw twister core: constants, request codes, FSM states, tempering.
// No dependencies.
`timescale 1ns / 1ps
package mtbd_pkg;
    localparam int STATE_DEPTH = 624;
    localparam int SHIFT_DIST  = 397;
    localparam int AW          = 10;
    localparam logic [31:0] MAT_A      = 32'h9908b0df;
    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc60000;
    localparam logic [31:0] SEED_DEF   = 32'd5489;
    localparam logic [AW-1:0] LAST_IDX = AW'(STATE_DEPTH - 1);
    localparam logic [AW-1:0] WRAP_M   = AW'(STATE_DEPTH - SHIFT_DIST);

    typedef enum logic [1:0] {
        REQ_SEED  = 2'd0,
        REQ_RAW   = 2'd1,
        REQ_BOUND = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        S_IDLE, S_SEED_MUL, S_SEED_WR, S_DRAW, S_TW_RD0, S_TW_RD1, S_TW_RD2,
        S_TW_CALC, S_RD, S_RD_WAIT, S_TEMPER, S_CHECK, S_OUT
    } t_state;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

>>> rtl/core/mtbd_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`timescale 1ns / 1ps
interface mtbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] seed_value;
    logic [63:0] upper_limit;
    modport source (output valid, req_type, seed_value, upper_limit, input ready);
    modport sink   (input valid, req_type, seed_value, upper_limit, output ready);
endinterface

interface mtbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;
    modport source (output valid, random_value, input ready);
    modport sink   (input valid, random_value, output ready);
endinterface

>>> rtl/core/mtbd_ram.sv
// State word memory: one write port, one registered read port.
// Depends on mtbd_pkg.
`timescale 1ns / 1ps
module mtbd_ram
    import mtbd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [STATE_DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/mersenne_twister_bounded_draw_core.sv
// Bounded-draw twister top level: sequencer, seeding multiplier and twist datapath.
// Depends on mtbd_pkg, mtbd_if, mtbd_ram.
`timescale 1ns / 1ps
// A request is taken only in idle and answered with exactly one result.
// A raw draw passes through S_DRAW, S_RD, S_RD_WAIT, S_TEMPER and S_CHECK and
// then presents its result in S_OUT; a bounded draw runs the same states for each
// word drawn, repeated on rejection, before S_OUT. A reseed walks the state memory
// through S_SEED_WR and S_SEED_MUL for each word. The first draw after a reseed or
// reset regenerates all 624 words through the single read port, by S_TW_RD0,
// S_TW_RD1, S_TW_RD2 and S_TW_CALC for each word (plus a default seeding if never
// seeded); the same regeneration recurs once every 624 words drawn.
module mersenne_twister_bounded_draw_core
    import mtbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mtbd_req_if.sink   i_req,
    mtbd_rsp_if.source o_rsp
);
    t_state r_state, n_state;
    logic [AW-1:0] r_left, n_left, r_ptr, n_ptr, r_k, n_k;
    logic          r_seeded, n_seeded, r_from_draw, n_from_draw;
    logic [1:0]    r_req, n_req;
    logic [63:0]   r_limit, n_limit, r_mask, n_mask, r_val, n_val, r_res, n_res;
    logic          r_hi, n_hi;       // next word goes to high half
    logic [31:0]   r_prev, n_prev, r_u, n_u, r_v, n_v, r_prod, n_prod;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic [63:0]   m;
    logic [31:0]   mix, tw, y;

    mtbd_ram u_ram (
        .i_clk  (i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // cover mask of the limit
    always_comb begin
        m = i_req.upper_limit;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
    end

    assign mix = (r_u & 32'h80000000) | (r_v & 32'h7fffffff);
    assign tw  = (mix >> 1) ^ (r_v[0] ? MAT_A : 32'd0);
    assign y   = temper(rdata);

    // next state and datapath
    always_comb begin
        n_state = r_state; n_left = r_left; n_ptr = r_ptr; n_k = r_k;
        n_seeded = r_seeded; n_from_draw = r_from_draw; n_req = r_req;
        n_limit = r_limit; n_mask = r_mask; n_val = r_val; n_res = r_res;
        n_hi = r_hi; n_prev = r_prev; n_u = r_u; n_v = r_v; n_prod = r_prod;
        we = 1'b0; waddr = r_k; wdata = r_prev; raddr = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.req_type; n_limit = i_req.upper_limit;
                    n_res = '0; n_val = '0;
                    case (t_req'(i_req.req_type))
                        REQ_SEED: begin
                            n_prev = i_req.seed_value; n_k = '0;
                            n_from_draw = 1'b0; n_state = S_SEED_WR;
                        end
                        REQ_RAW: begin
                            n_mask = 64'hffffffff; n_hi = 1'b0; n_state = S_DRAW;
                        end
                        REQ_BOUND: begin
                            n_mask = m; n_hi = (m[63:32] != '0);
                            n_state = (m == '0) ? S_OUT : S_DRAW;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SEED_WR: begin
                we = 1'b1; waddr = r_k; wdata = r_prev;
                if (r_k == LAST_IDX) begin
                    // keep the full count when seeding ahead of a regeneration
                    n_seeded = 1'b1; n_left = r_from_draw ? r_left : AW'(1);
                    n_state = r_from_draw ? S_TW_RD0 : S_OUT;
                    n_k = '0;
                end else begin
                    n_prod = (r_prev ^ (r_prev >> 30)) * INIT_MULT;
                    n_k = r_k + 1'b1;
                    n_state = S_SEED_MUL;
                end
            end
            S_SEED_MUL: begin
                n_prev = r_prod + 32'(r_k);
                n_state = S_SEED_WR;
            end
            S_DRAW: begin
                n_left = r_left - 1'b1;
                if (n_left == '0) begin
                    n_left = AW'(STATE_DEPTH); n_ptr = '0; n_k = '0;
                    if (!r_seeded) begin
                        n_prev = SEED_DEF; n_from_draw = 1'b1; n_state = S_SEED_WR;
                    end else begin
                        n_state = S_TW_RD0;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_TW_RD0: begin
                raddr = r_k; n_state = S_TW_RD1;
            end
            S_TW_RD1: begin
                raddr = (r_k == LAST_IDX) ? '0 : r_k + 1'b1;
                n_u = rdata; n_state = S_TW_RD2;
            end
            S_TW_RD2: begin
                raddr = (r_k < WRAP_M) ? r_k + AW'(SHIFT_DIST) : r_k - WRAP_M;
                n_v = rdata; n_state = S_TW_CALC;
            end
            S_TW_CALC: begin
                we = 1'b1; waddr = r_k; wdata = rdata ^ tw;
                if (r_k == LAST_IDX) begin
                    n_state = S_RD;
                end else begin
                    n_k = r_k + 1'b1; n_state = S_TW_RD0;
                end
            end
            S_RD: begin
                raddr = r_ptr; n_ptr = r_ptr + 1'b1; n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                // hold the read address so the word stays on the port
                raddr = r_ptr - 1'b1;
                n_state = S_TEMPER;
            end
            S_TEMPER: begin
                if (r_hi) begin
                    n_val = {y, 32'd0} & r_mask;
                end else begin
                    n_val = (r_val | {32'd0, y}) & r_mask;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_val > r_limit && t_req'(r_req) == REQ_BOUND) begin
                    n_hi = (r_mask[63:32] != '0); n_val = '0; n_state = S_DRAW;
                end else if (r_hi) begin
                    n_hi = 1'b0; n_state = S_DRAW;
                end else begin
                    n_res = r_val; n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_req.ready        = (r_state == S_IDLE);
        o_rsp.valid        = (r_state == S_OUT);
        o_rsp.random_value = r_res;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_left <= AW'(1); r_ptr <= '0; r_seeded <= 1'b0;
        end else begin
            r_state <= n_state; r_left <= n_left; r_ptr <= n_ptr; r_seeded <= n_seeded;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_from_draw <= n_from_draw; r_req <= n_req; r_limit <= n_limit;
        r_mask <= n_mask; r_val <= n_val; r_res <= n_res; r_hi <= n_hi;
        r_prev <= n_prev; r_u <= n_u; r_v <= n_v; r_prod <= n_prod;
    end
endmodule

>>> bench/mersenne_twister_bounded_draw_core_test.sv
// Testbench for the bounded-draw twister core: drives requests, predicts each
// drawn value with an in-bench generator and checks results in order.
// Depends on mtbd_pkg, mtbd_if and mersenne_twister_bounded_draw_core.
`timescale 1ns / 1ps
module mersenne_twister_bounded_draw_core_test;
    import mtbd_pkg::*;

    // Generator model and queue of expected results
    class draw_scoreboard;
        logic [31:0] words [STATE_DEPTH];
        logic [9:0]  left_cnt;
        logic [9:0]  rd_ptr;
        bit          seeded;
        logic [63:0] expected_values [$];
        int          errors;

        function new();
            foreach (words[i]) words[i] = '0;
            left_cnt = 10'd1;
            rd_ptr   = '0;
            seeded   = 0;
            errors   = 0;
        endfunction

        function void seed_words(logic [31:0] s);
            logic [31:0] p;
            words[0] = s;
            for (int j = 1; j < STATE_DEPTH; j++) begin
                p = words[j-1];
                words[j] = 32'(64'(INIT_MULT) * 64'(p ^ (p >> 30)) + 64'(j));
            end
            left_cnt = 10'd1;
            seeded   = 1;
        endfunction

        function void twist();
            logic [31:0] u, v, mix;
            if (!seeded) seed_words(SEED_DEF);
            left_cnt = 10'(STATE_DEPTH);
            rd_ptr   = '0;
            for (int k = 0; k < STATE_DEPTH; k++) begin
                u = words[k];
                v = words[(k + 1) % STATE_DEPTH];
                mix = {u[31], v[30:0]};
                words[k] = words[(k + SHIFT_DIST) % STATE_DEPTH] ^ (mix >> 1)
                           ^ (v[0] ? MAT_A : 32'h0);
            end
        endfunction

        function logic [31:0] next_word();
            logic [31:0] y;
            left_cnt = left_cnt - 10'd1;
            if (left_cnt == 0) twist();
            y = words[rd_ptr % STATE_DEPTH];
            rd_ptr = rd_ptr + 10'd1;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        endfunction

        function logic [63:0] limited_value(logic [63:0] lim);
            logic [63:0] mask, val;
            bit ok;
            mask = lim;
            for (int s = 1; s < 64; s = s * 2) mask = mask | (mask >> s);
            forever begin
                val = '0;
                ok  = 1;
                if (mask[63:32] != 0) begin
                    val = {next_word(), 32'h0} & mask;
                    if (val > lim) ok = 0;
                end
                if (ok && mask != 0) begin
                    val = (val | 64'(next_word())) & mask;
                    if (val > lim) ok = 0;
                end
                if (ok) return val;
            end
        endfunction

        function void note_request(t_req kind, logic [31:0] seed, logic [63:0] lim);
            logic [63:0] res;
            res = '0;
            case (kind)
                REQ_SEED:  seed_words(seed);
                REQ_RAW:   res = 64'(next_word());
                REQ_BOUND: res = limited_value(lim);
                default:   res = '0;
            endcase
            expected_values.push_back(res);
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (expected_values.size() == 0) begin
                $error("unexpected result random_value=%h", got);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (got !== want) begin
                $error("random_value mismatch: expected %h actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mtbd_req_if req_ch();
    mtbd_rsp_if rsp_ch();
    draw_scoreboard board;
    bit  send_done;
    bit  hold_rsp;
    int  idle_cycles;

    mersenne_twister_bounded_draw_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // Note accepted requests, check results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(t_req'(req_ch.req_type), req_ch.seed_value,
                                   req_ch.upper_limit);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.random_value);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 40000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stall the result side on its own pattern, with one long hold-off that
    // outlasts a full regeneration so a finished result is left waiting
    initial begin
        int mode;
        int cyc;
        cyc = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(1, 30)) begin
                @(posedge i_clk);
                cyc++;
                hold_rsp = (cyc >= 2000 && cyc < 7000);
                rsp_ch.ready <= !hold_rsp && (mode == 0 ? 1'b1 :
                                mode == 1 ? ($urandom_range(0, 3) != 0) : $urandom_range(0, 1));
            end
        end
    end

    // Offer one request and hold it until transferred; gaps between bursts
    task automatic send_request(t_req kind, logic [31:0] seed, logic [63:0] lim);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.seed_value  <= seed;
        req_ch.upper_limit <= lim;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_sender();
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_limit();
        int   sel;
        int   bits;
        sel = $urandom_range(0, 9);
        bits = $urandom_range(1, 64);
        case (sel)
            0: return '0;
            1: return 64'($urandom_range(1, 16));
            2, 3: return 64'($urandom());
            4: return {32'($urandom()), 32'($urandom())};
            5: return ({32'($urandom()), 32'($urandom())}) >> (64 - bits);
            6: return (64'd1 << (bits - 1));
            7: return (64'd1 << (bits - 1)) | 64'($urandom_range(0, 3));
            default: return ({32'($urandom()), 32'($urandom())}) | 64'h8000_0000_0000_0000;
        endcase
    endfunction

    // Stimulus: directed cases, then random bursts
    initial begin
        int   burst;
        int   sel;
        t_req kind;
        board = new();
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_NONE;
        req_ch.seed_value  <= '0;
        req_ch.upper_limit <= '0;
        i_rst_n <= 1'b0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Draw before any seed, then limit extremes, the idle code, and reseeds with draws
        send_request(REQ_RAW, 32'h0, 64'h0);
        send_request(REQ_BOUND, 32'h0, 64'h0);
        send_request(REQ_BOUND, 32'h0, 64'h1);
        send_request(REQ_BOUND, 32'h0, 64'hFFFF_FFFF);
        send_request(REQ_BOUND, 32'h0, 64'h1_0000_0000);
        send_request(REQ_BOUND, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_BOUND, 32'h0, 64'h8000_0000_0000_0000);
        send_request(REQ_BOUND, 32'h0, 64'h8000_0000);
        send_request(REQ_NONE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_SEED, 32'h0, 64'h0);
        send_request(REQ_RAW, 32'h0, 64'h0);
        send_request(REQ_SEED, 32'hFFFF_FFFF, 64'h0);
        send_request(REQ_RAW, 32'h0, 64'h0);
        send_request(REQ_BOUND, 32'h0, 64'h5555_5555_5555_5555);
        send_request(REQ_SEED, 32'd5489, 64'h0);
        send_request(REQ_BOUND, 32'h0, 64'hAAAA_AAAA);
        pause_sender();

        // Random part; reseeds are rare since each walks the whole state
        for (int n = 0; n < 750; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                sel = $urandom_range(0, 99);
                kind = sel < 2 ? REQ_SEED : sel < 4 ? REQ_NONE :
                       sel < 50 ? REQ_RAW : REQ_BOUND;
                send_request(kind, $urandom(), pick_limit());
            end
            if ($urandom_range(0, 3) != 0) pause_sender();
        end
        req_ch.valid <= 1'b0;
        send_done = 1;
    end

    // Drain and finish
    initial begin
        send_done = 0;
        wait (send_done);
        while (board.expected_values.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/mtbd_pkg.sv
rtl/core/mtbd_if.sv
rtl/core/mtbd_ram.sv
rtl/core/mersenne_twister_bounded_draw_core.sv
bench/mersenne_twister_bounded_draw_core_test.sv
